/* sv/rth_pkg.sv */
package rth_pkg;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 63;
  localparam int THR_WIDTH       = 63;
  localparam int TMIN_WIDTH      = 31;
  localparam int PIPE_DEPTH      = 9;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_DIR_X     = 3'd0,
    REG_DIR_Y     = 3'd1,
    REG_DIR_Z     = 3'd2,
    REG_THRESHOLD = 3'd3,
    REG_T_MIN     = 3'd4
  } cfg_reg_t;

endpackage

/* sv/ray_triangle_hit_test_top.sv */
// Ray/triangle hit test, one triangle per clock.
// Input channel: a transfer happens at a rising edge with start high and busy
// low. busy is always low, so a new triangle may be presented every cycle.
// Each transfer carries the ray origin and the three vertices, signed fixed
// point with FRAC_BITS fraction bits.
// Result channel: done is high for exactly one cycle per input transfer and
// hit is valid in that cycle; hit is low whenever done is low. The result of
// a transfer comes out of the nine-stage multiply and compare pipeline, and
// the throughput is one item per cycle.
// Configuration: cfg_we with cfg_index and cfg_data writes the ray direction,
// the parallel threshold or t_min; writes to other indexes are dropped. Users
// must write registers only while no item is in flight; the block does not
// enforce this. Reset: rst, synchronous, empties the pipeline and loads
// direction (1,0,0), zero threshold and t_min. Results are never stalled.
module ray_triangle_hit_test_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cfg_we,
  input  logic [rth_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [rth_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic signed [COORD_WIDTH-1:0]       origin_x,
  input  logic signed [COORD_WIDTH-1:0]       origin_y,
  input  logic signed [COORD_WIDTH-1:0]       origin_z,
  input  logic signed [COORD_WIDTH-1:0]       v0_x,
  input  logic signed [COORD_WIDTH-1:0]       v0_y,
  input  logic signed [COORD_WIDTH-1:0]       v0_z,
  input  logic signed [COORD_WIDTH-1:0]       v1_x,
  input  logic signed [COORD_WIDTH-1:0]       v1_y,
  input  logic signed [COORD_WIDTH-1:0]       v1_z,
  input  logic signed [COORD_WIDTH-1:0]       v2_x,
  input  logic signed [COORD_WIDTH-1:0]       v2_y,
  input  logic signed [COORD_WIDTH-1:0]       v2_z,
  output logic                                done,
  output logic                                hit
);
  import rth_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int EW   = CW + 1;
  localparam int HW   = 2 * CW + 2;
  localparam int QW   = 2 * CW + 3;
  localparam int SPL  = CW + 1;
  localparam int PW   = 2 * CW + 4;
  localparam int XW   = 2 * CW + 2;
  localparam int DW   = 3 * CW + 6;
  localparam int CMPW = ((DW > THR_WIDTH) ? DW : THR_WIDTH) + 1;
  localparam int LB   = (DW + 3) / 4;
  localparam int PPW  = TMIN_WIDTH + LB;
  localparam int LW   = ((DW + FRAC_BITS > TMIN_WIDTH + DW) ?
                         DW + FRAC_BITS : TMIN_WIDTH + DW) + 4;

  logic signed [CW-1:0]         dir [3];
  logic [THR_WIDTH-1:0]         thr;
  logic [TMIN_WIDTH-1:0]        tmin;
  logic [PIPE_DEPTH-1:0]        valid;

  logic signed [EW-1:0]         e1_1 [3], e2_1 [3], s_1 [3];
  logic signed [EW-1:0]         e1_2 [3], e2_2 [3], s_2 [3];
  logic signed [XW-1:0]         hpa_2 [3], hpb_2 [3], qpa_2 [3], qpb_2 [3];
  logic signed [EW-1:0]         e1_3 [3], e2_3 [3], s_3 [3];
  logic signed [HW-1:0]         h_3 [3];
  logic signed [QW-1:0]         q_3 [3];
  logic signed [PW-1:0]         al_4 [3], ah_4 [3], ul_4 [3], uh_4 [3];
  logic signed [PW-1:0]         vl_4 [3], vh_4 [3], tl_4 [3], th_4 [3];
  logic signed [DW-1:0]         a_5, un_5, vn_5, tn_5;
  logic signed [DW-1:0]         a_6, un_6, vn_6, tn_6;
  logic                         thr_ok_7, un_ok_7, vn_ok_7, sum_ok_7;
  logic signed [LW-1:0]         lhs_7;
  logic [PPW-1:0]               pp_7 [4];
  logic                         flags_8;
  logic signed [LW-1:0]         lhs_8;
  logic [LW-2:0]                rhs_8;
  logic                         hit_9;

  logic signed [EW-1:0]         org_w [3], p0_w [3], p1_w [3], p2_w [3];
  logic [4*LB-1:0]              amag_w;
  logic signed [DW:0]           uvsum_w;

  assign busy = 1'b0;
  assign done = valid[PIPE_DEPTH-1];
  assign hit  = hit_9;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir[0] <= CW'(1 << FRAC_BITS);
      dir[1] <= '0;
      dir[2] <= '0;
      thr    <= '0;
      tmin   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIR_X:     dir[0] <= cfg_data[CW-1:0];
        REG_DIR_Y:     dir[1] <= cfg_data[CW-1:0];
        REG_DIR_Z:     dir[2] <= cfg_data[CW-1:0];
        REG_THRESHOLD: thr    <= cfg_data[THR_WIDTH-1:0];
        REG_T_MIN:     tmin   <= cfg_data[TMIN_WIDTH-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      hit_9 <= 1'b0;
    end else begin
      valid <= {valid[PIPE_DEPTH-2:0], start && !busy};
      hit_9 <= valid[PIPE_DEPTH-2] && flags_8 && (lhs_8 > $signed({1'b0, rhs_8}));
    end
  end

  always_comb begin
    org_w[0] = EW'(origin_x); org_w[1] = EW'(origin_y); org_w[2] = EW'(origin_z);
    p0_w[0]  = EW'(v0_x);     p0_w[1]  = EW'(v0_y);     p0_w[2]  = EW'(v0_z);
    p1_w[0]  = EW'(v1_x);     p1_w[1]  = EW'(v1_y);     p1_w[2]  = EW'(v1_z);
    p2_w[0]  = EW'(v2_x);     p2_w[1]  = EW'(v2_y);     p2_w[2]  = EW'(v2_z);
    amag_w   = (4*LB)'($unsigned(a_6));
    uvsum_w  = (DW+1)'(un_6) + (DW+1)'(vn_6);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      e1_1[k] <= p1_w[k] - p0_w[k];
      e2_1[k] <= p2_w[k] - p0_w[k];
      s_1[k]  <= org_w[k] - p0_w[k];
    end

    hpa_2[0] <= XW'(dir[1] * e2_1[2]);  hpb_2[0] <= XW'(dir[2] * e2_1[1]);
    hpa_2[1] <= XW'(dir[2] * e2_1[0]);  hpb_2[1] <= XW'(dir[0] * e2_1[2]);
    hpa_2[2] <= XW'(dir[0] * e2_1[1]);  hpb_2[2] <= XW'(dir[1] * e2_1[0]);
    qpa_2[0] <= XW'(s_1[1] * e1_1[2]);  qpb_2[0] <= XW'(s_1[2] * e1_1[1]);
    qpa_2[1] <= XW'(s_1[2] * e1_1[0]);  qpb_2[1] <= XW'(s_1[0] * e1_1[2]);
    qpa_2[2] <= XW'(s_1[0] * e1_1[1]);  qpb_2[2] <= XW'(s_1[1] * e1_1[0]);
    e1_2 <= e1_1;
    e2_2 <= e2_1;
    s_2  <= s_1;

    for (int k = 0; k < 3; k++) begin
      h_3[k] <= HW'(hpa_2[k]) - HW'(hpb_2[k]);
      q_3[k] <= QW'(qpa_2[k]) - QW'(qpb_2[k]);
    end
    e1_3 <= e1_2;
    e2_3 <= e2_2;
    s_3  <= s_2;

    for (int k = 0; k < 3; k++) begin
      al_4[k] <= PW'(e1_3[k] * $signed({1'b0, h_3[k][SPL-1:0]}));
      ah_4[k] <= PW'(e1_3[k] * $signed(h_3[k][HW-1:SPL]));
      ul_4[k] <= PW'(s_3[k] * $signed({1'b0, h_3[k][SPL-1:0]}));
      uh_4[k] <= PW'(s_3[k] * $signed(h_3[k][HW-1:SPL]));
      vl_4[k] <= PW'(dir[k] * $signed({1'b0, q_3[k][SPL-1:0]}));
      vh_4[k] <= PW'(dir[k] * $signed(q_3[k][QW-1:SPL]));
      tl_4[k] <= PW'(e2_3[k] * $signed({1'b0, q_3[k][SPL-1:0]}));
      th_4[k] <= PW'(e2_3[k] * $signed(q_3[k][QW-1:SPL]));
    end

    a_5  <= (DW'(ah_4[0]) <<< SPL) + DW'(al_4[0]) + (DW'(ah_4[1]) <<< SPL)
          + DW'(al_4[1]) + (DW'(ah_4[2]) <<< SPL) + DW'(al_4[2]);
    un_5 <= (DW'(uh_4[0]) <<< SPL) + DW'(ul_4[0]) + (DW'(uh_4[1]) <<< SPL)
          + DW'(ul_4[1]) + (DW'(uh_4[2]) <<< SPL) + DW'(ul_4[2]);
    vn_5 <= (DW'(vh_4[0]) <<< SPL) + DW'(vl_4[0]) + (DW'(vh_4[1]) <<< SPL)
          + DW'(vl_4[1]) + (DW'(vh_4[2]) <<< SPL) + DW'(vl_4[2]);
    tn_5 <= (DW'(th_4[0]) <<< SPL) + DW'(tl_4[0]) + (DW'(th_4[1]) <<< SPL)
          + DW'(tl_4[1]) + (DW'(th_4[2]) <<< SPL) + DW'(tl_4[2]);

    if (a_5[DW-1]) begin
      a_6  <= -a_5;
      un_6 <= -un_5;
      vn_6 <= -vn_5;
      tn_6 <= -tn_5;
    end else begin
      a_6  <= a_5;
      un_6 <= un_5;
      vn_6 <= vn_5;
      tn_6 <= tn_5;
    end

    thr_ok_7 <= CMPW'($unsigned(a_6)) > CMPW'(thr);
    un_ok_7  <= !un_6[DW-1] && (un_6 <= a_6);
    vn_ok_7  <= !vn_6[DW-1];
    sum_ok_7 <= uvsum_w <= (DW+1)'(a_6);
    lhs_7    <= LW'(tn_6) <<< FRAC_BITS;
    for (int k = 0; k < 4; k++) begin
      pp_7[k] <= PPW'(tmin) * PPW'(amag_w[k*LB +: LB]);
    end

    flags_8 <= thr_ok_7 && un_ok_7 && vn_ok_7 && sum_ok_7;
    lhs_8   <= lhs_7;
    rhs_8   <= (LW-1)'(pp_7[0]) + ((LW-1)'(pp_7[1]) << LB)
             + ((LW-1)'(pp_7[2]) << (2*LB)) + ((LW-1)'(pp_7[3]) << (3*LB));
  end

endmodule

/* sv/rth_checker.sv */
module rth_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic hit
);
  import rth_pkg::*;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised by a fully pipelined block");

  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result shown without a matching input transfer");

  a_hit_only_with_done: assert property (@(posedge clk) !done |-> !hit)
    else $error("hit high outside a result transfer");

  a_reset_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("result shown right after reset");

endmodule

bind ray_triangle_hit_test_top rth_checker u_rth_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .hit(hit)
);
